>>> rtl/core/tet_pkg.sv
// package for the tick extender with time table
// types, constants and shared sizes; no dependencies
`timescale 1ns / 1ps
package tet_pkg;
  localparam int MaxEntries = 64;
  localparam int IdxW = $clog2(MaxEntries);
  localparam int CntW = $clog2(MaxEntries + 1);
  localparam logic [31:0] WrapLimit = 32'h0fff_ffff;
  localparam logic [9:0] SpanReset = 10'd10;
  localparam logic [13:0] PeriodReset = 14'd1000;
  localparam logic CfgTickSpan = 1'b0;
  localparam logic CfgCheckPeriod = 1'b1;
  localparam logic ActSample = 1'b0;
  localparam logic ActQuery = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] raw_tick;
    logic [63:0] wall_time;
    logic [63:0] query_tick;
  } in_item_t;

  typedef struct packed {
    logic [63:0] current_tick;
    logic [63:0] converted_time;
    logic        entry_added;
    logic [6:0]  entry_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic tick;       // extend raw tick into ext
    logic sample;     // run drift check and anchor update
    logic wr_en;      // write table at wr_idx
    logic shift_en;   // move registered read data down into wr_idx (eviction)
    logic rd_en;      // read table at rd_idx
    logic [IdxW-1:0] rd_idx;
    logic [IdxW-1:0] wr_idx;
    logic q_init;     // start query search
    logic q_step;     // examine registered read data
    logic finish;     // load output register
  } tet_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic action;
    logic need_seed;
    logic need_add;
    logic q_zero;
    logic q_hit;
  } tet_sts_t;
endpackage

>>> rtl/core/tet_datapath.sv
// datapath: tick extension, drift check, entry table and query search
// depends on tet_pkg
`timescale 1ns / 1ps
module tet_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tet_pkg::in_item_t   in_data,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [13:0]         cfg_wdata,
  input  tet_pkg::tet_cmd_t   cmd,
  output tet_pkg::tet_sts_t   sts,
  output tet_pkg::out_item_t  res,
  output logic [tet_pkg::CntW-1:0] cnt
);
  import tet_pkg::*;

  logic [9:0]  span_r;
  logic [13:0] period_r;
  in_item_t    item_r;
  logic [31:0] last_raw_r, wrap_r;
  logic [63:0] start_r, ext_r, ref_wall_r, ref_tick_r;
  logic [15:0] accum_r;
  logic        started_r, checked_r, seeded_r, added_r, hit_r;
  logic [CntW-1:0] cnt_r;
  logic [63:0] tick_mem [MaxEntries];
  logic [63:0] time_mem [MaxEntries];
  logic [63:0] rd_tick_r, rd_time_r, conv_r;
  out_item_t   res_r;

  // sample path
  logic [31:0] raw_v, wrap_v;
  logic [63:0] t64, ext_v, start_v, base_w, base_t, pred, adiff;
  logic [15:0] acc_v;
  logic        check_due, add_v;

  // tick extension, registered into ext_r
  always_comb begin
    raw_v  = item_r.raw_tick;
    wrap_v = wrap_r;
    if (last_raw_r > item_r.raw_tick) begin
      if (last_raw_r - item_r.raw_tick >= WrapLimit) wrap_v = wrap_r + 32'd1;
      else raw_v = last_raw_r;
    end
    t64     = {wrap_v, raw_v};
    start_v = started_r ? start_r : t64;
    ext_v   = t64 - start_v + 64'd1;
  end

  // drift check against the registered extended tick
  always_comb begin
    base_w  = seeded_r ? ref_wall_r : item_r.wall_time;
    base_t  = seeded_r ? ref_tick_r : ext_r;
    acc_v   = accum_r + {6'd0, span_r};
    check_due = (acc_v >= {2'd0, period_r}) || !checked_r;
    pred    = item_r.wall_time - base_w + base_t;
    adiff   = (pred > ext_r) ? pred - ext_r : ext_r - pred;
    add_v   = check_due && ((item_r.wall_time < base_w) || (adiff >= {54'd0, span_r}));
  end

  assign sts.action    = item_r.action;
  assign sts.need_seed = !seeded_r;
  assign sts.need_add  = add_v;
  assign sts.q_zero    = (item_r.query_tick == 64'd0);
  assign sts.q_hit     = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= SpanReset; period_r <= PeriodReset;
      last_raw_r <= '0; wrap_r <= '0; start_r <= '0; ext_r <= '0;
      ref_wall_r <= '0; ref_tick_r <= '0; accum_r <= '0;
      started_r <= 1'b0; checked_r <= 1'b0; seeded_r <= 1'b0;
      cnt_r <= '0; added_r <= 1'b0; hit_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CfgTickSpan) span_r <= cfg_wdata[9:0];
        else period_r <= cfg_wdata;
      end
      if (cmd.load) begin
        item_r  <= in_data;
        added_r <= 1'b0;
      end
      if (cmd.tick) begin
        last_raw_r <= raw_v; wrap_r <= wrap_v; start_r <= start_v;
        started_r <= 1'b1; ext_r <= ext_v;
      end
      if (cmd.sample) begin
        seeded_r <= 1'b1;
        ref_wall_r <= base_w; ref_tick_r <= base_t;
        if (check_due) begin
          checked_r <= 1'b1;
          accum_r <= '0;
          if (add_v) begin
            ref_wall_r <= item_r.wall_time;
            ref_tick_r <= ext_r;
            added_r <= 1'b1;
          end
        end else begin
          accum_r <= acc_v;
        end
      end
      if (cmd.wr_en) begin
        if (cnt_r < CntW'(MaxEntries)) cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.q_init) hit_r <= 1'b0;
      if (cmd.q_step && !hit_r && rd_tick_r <= item_r.query_tick) hit_r <= 1'b1;
    end
  end

  // entry table; eviction shifts entries down one at a time via the read register
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      tick_mem[cmd.wr_idx] <= ext_r;
      time_mem[cmd.wr_idx] <= item_r.wall_time;
    end else if (cmd.shift_en) begin
      tick_mem[cmd.wr_idx] <= rd_tick_r;
      time_mem[cmd.wr_idx] <= rd_time_r;
    end
    if (cmd.rd_en) begin
      rd_tick_r <= tick_mem[cmd.rd_idx];
      rd_time_r <= time_mem[cmd.rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_init) conv_r <= 64'd0;
    if (cmd.q_step && !hit_r && rd_tick_r <= item_r.query_tick)
      conv_r <= rd_time_r + (item_r.query_tick - rd_tick_r);
    if (cmd.finish) begin
      res_r.current_tick <= ext_r;
      if (item_r.action == ActSample || sts.q_zero)
        res_r.converted_time <= 64'd0;
      else
        res_r.converted_time <= (conv_r == 64'd0) ? 64'd1 : conv_r;
      res_r.entry_added <= added_r;
      res_r.entry_count <= 7'(cnt_r);
    end
  end

  assign res = res_r;
  assign cnt = cnt_r;
endmodule

>>> rtl/core/tet_ctrl.sv
// controller: sequences sample update, table write/eviction and query walk
// depends on tet_pkg
`timescale 1ns / 1ps
module tet_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  tet_pkg::tet_sts_t sts,
  input  logic [tet_pkg::CntW-1:0] cnt,
  output tet_pkg::tet_cmd_t cmd
);
  import tet_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_SAMP = 4'd1, S_SEED = 4'd2,
    S_ADD = 4'd3, S_ERD = 4'd4, S_EWR = 4'd5, S_QRD = 4'd6, S_QCHK = 4'd7,
    S_FIN = 4'd8, S_OUT = 4'd9, S_QWT = 4'd10, S_CHK = 4'd11;

  logic [3:0] st_r, st_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic pend_r, pend_nxt;      // drift entry still to add after seeding
  logic ovalid_r, ovalid_nxt;
  logic full;

  assign full = (cnt == CntW'(MaxEntries));

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; pend_nxt = pend_r; ovalid_nxt = ovalid_r;
    cmd = '0;
    in_ready = 1'b0;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          st_nxt = S_SAMP;
        end
      end
      S_SAMP: begin
        if (sts.action == ActQuery) begin
          cmd.q_init = 1'b1;
          if (sts.q_zero || cnt == '0) st_nxt = S_FIN;
          else begin
            idx_nxt = IdxW'(cnt - 1'b1);
            st_nxt = S_QRD;
          end
        end else begin
          cmd.tick = 1'b1;
          st_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cmd.sample = 1'b1;
        pend_nxt = sts.need_add;
        st_nxt = sts.need_seed ? S_SEED : (sts.need_add ? S_ADD : S_FIN);
      end
      S_SEED, S_ADD: begin
        if (st_r == S_SEED) pend_nxt = pend_r;
        if (full) begin
          idx_nxt = IdxW'(1);
          st_nxt = S_ERD;
        end else begin
          cmd.wr_en = 1'b1;
          cmd.wr_idx = IdxW'(cnt);
          if (st_r == S_SEED && pend_r) st_nxt = S_ADD;
          else begin
            st_nxt = S_FIN;
          end
          pend_nxt = 1'b0;
        end
      end
      S_ERD: begin
        if (idx_r == IdxW'(MaxEntries - 1)) begin
          cmd.wr_en = 1'b1;
          cmd.wr_idx = IdxW'(MaxEntries - 1);
          st_nxt = S_FIN;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_idx = idx_r + 1'b1;
          st_nxt = S_EWR;
        end
      end
      S_EWR: begin
        cmd.shift_en = 1'b1;
        cmd.wr_idx = idx_r;
        idx_nxt = idx_r + 1'b1;
        st_nxt = S_ERD;
      end
      S_QRD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_idx = idx_r;
        st_nxt = S_QCHK;
      end
      S_QCHK: begin
        cmd.q_step = 1'b1;
        st_nxt = S_QWT;
      end
      S_QWT: begin
        if (sts.q_hit || idx_r == '0) st_nxt = S_FIN;
        else begin
          idx_nxt = idx_r - 1'b1;
          st_nxt = S_QRD;
        end
      end
      S_FIN: begin
        if (!ovalid_r || out_ready) begin
          cmd.finish = 1'b1;
          ovalid_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; idx_r <= '0; pend_r <= 1'b0; ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; idx_r <= idx_nxt; pend_r <= pend_nxt; ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;

`ifndef NO_ASSERTIONS
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> st_r == S_IDLE) else $error("load outside idle");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid) else $error("finish without valid");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_en && cmd.shift_en)) else $error("write and shift together");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt <= CntW'(MaxEntries)) else $error("count overflow");
`endif
endmodule

>>> rtl/core/tick_extender_with_time_table.sv
// top level of the tick extender with time table
// depends on tet_pkg, tet_ctrl, tet_datapath
`timescale 1ns / 1ps
// Extends a 32-bit millisecond counter to 64 bits and keeps a table of up
// to MaxEntries (tick, wall time) pairs. One transaction at a time: a
// sample passes tick extension, drift check, table writes for a seed or
// an appended pair as needed, and finish. A write to a full table evicts
// the second entry: the entries above move down one at a time, each
// read into the read register, then written one slot lower. A query of
// zero or on an empty table goes straight to finish; otherwise the table
// is walked newest first, one entry at a time, until a hit or the oldest
// entry. A stalled receiver holds the finish step. A new input is taken
// while the previous result waits in the output register; the user must
// write configuration only while idle, which the block does not enforce.
module tick_extender_with_time_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tet_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tet_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [13:0]        cfg_wdata
);
  import tet_pkg::*;

  tet_cmd_t cmd;
  tet_sts_t sts;
  logic [CntW-1:0] cnt;

  // sequencer
  tet_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts, .cnt, .cmd
  );

  // state, table and arithmetic
  tet_datapath u_dp (
    .clk, .rst_n, .in_data, .cfg_we, .cfg_idx, .cfg_wdata,
    .cmd, .sts, .res(out_data), .cnt
  );
endmodule
